### hw/rtl/keuf_pkg.sv
// Shared constants and state type for the Kruskal union-find engine
`timescale 1ns / 1ps

package keuf_pkg;

  localparam int COUNT_W         = 9;
  localparam int NODE_W          = 8;
  localparam int TOTAL_W         = 39;
  localparam int SIZE_OUT_W      = 9;
  localparam int DEF_MAX_NODES   = 256;
  localparam int DEF_WEIGHT_BITS = 31;

  localparam logic [COUNT_W-1:0] NODE_COUNT_RST = 9'd256;

  localparam logic OP_CLEAR = 1'b0;
  localparam logic OP_EDGE  = 1'b1;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_SWEEP,
    ST_WALK,
    ST_COMP_RD,
    ST_COMP_WR,
    ST_MERGE_SMALL,
    ST_MERGE_BIG,
    ST_DONE
  } keuf_state_t;

endpackage

### hw/rtl/kruskal_edge_union_find.sv
// Union-find accept stage for Kruskal: root walks, path compression, union by size
// Edge item: root walk and path compression from a, then from b, then two merge writes
//   (small set, then big root), skipped when in one set; all on one node memory (1R1W).
// Bad-node item goes straight to the result; clear item makes one memory write per node in use.
// One item at a time; the next is taken while a finished result waits in the output register.
// Reset (synchronous rst_n): memory init sets every node as its own set, in_ready low; total 0, node count 256.
`timescale 1ns / 1ps

module kruskal_edge_union_find
  import keuf_pkg::*;
#(
  parameter int MAX_NODES   = DEF_MAX_NODES,
  parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_op,
  input  logic [NODE_W-1:0]      in_node_a,
  input  logic [NODE_W-1:0]      in_node_b,
  input  logic [WEIGHT_BITS-1:0] in_edge_weight,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   out_accepted,
  output logic                   out_bad_node,
  output logic [TOTAL_W-1:0]     out_running_total,
  output logic [SIZE_OUT_W-1:0]  out_merged_size,
  input  logic                   cfg_wr_en,
  input  logic [COUNT_W-1:0]     cfg_wr_data
);

  localparam int IDX_W  = $clog2(MAX_NODES);
  localparam int CNT_W  = $clog2(MAX_NODES + 1);
  localparam int UW     = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
  localparam int SZ_W   = CNT_W;
  localparam int WORD_W = SZ_W + IDX_W;

  localparam logic [UW-1:0]    MAXN_U = UW'(MAX_NODES);
  localparam logic [CNT_W-1:0] MAXN_C = CNT_W'(MAX_NODES);
  localparam logic [CNT_W-1:0] LAST_C = CNT_W'(MAX_NODES - 1);
  localparam logic [SZ_W:0]    MAXN_S = (SZ_W + 1)'(MAX_NODES);

  // node memory word: {set size, parent link}
  logic [WORD_W-1:0] mem [MAX_NODES];
  logic [WORD_W-1:0] rdata_r;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic [IDX_W-1:0]  mem_raddr;

  keuf_state_t state_r, state_nxt;

  logic [COUNT_W-1:0]     node_count_r;
  logic [TOTAL_W-1:0]     total_r, total_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [CNT_W-1:0]       sweep_end_r, sweep_end_nxt;
  logic [IDX_W-1:0]       cur_r, cur_nxt;
  logic [IDX_W-1:0]       start_r, start_nxt;
  logic [IDX_W-1:0]       node_b_r, node_b_nxt;
  logic [IDX_W-1:0]       root_r, root_nxt;
  logic [IDX_W-1:0]       ra_r, ra_nxt;
  logic [SZ_W-1:0]        size_a_r, size_a_nxt;
  logic [SZ_W-1:0]        size_b_r, size_b_nxt;
  logic                   side_r, side_nxt;
  logic [WEIGHT_BITS-1:0] w_r, w_nxt;
  logic                   res_acc_r, res_acc_nxt;
  logic                   res_bad_r, res_bad_nxt;
  logic [SZ_W-1:0]        res_size_r, res_size_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic                  out_accepted_r, out_accepted_nxt;
  logic                  out_bad_node_r, out_bad_node_nxt;
  logic [TOTAL_W-1:0]    out_total_r, out_total_nxt;
  logic [SIZE_OUT_W-1:0] out_size_r, out_size_nxt;

  logic [IDX_W-1:0] rd_parent;
  logic [SZ_W-1:0]  rd_size;
  logic [UW-1:0]    nc_u, n_use, a_u, b_u;
  logic [IDX_W-1:0] a_idx, b_idx;
  logic             b_big;
  logic [IDX_W-1:0] big_idx, small_idx;
  logic [SZ_W-1:0]  small_size;
  logic [SZ_W:0]    size_sum;
  logic [SZ_W-1:0]  size_sat;
  logic [TOTAL_W:0] total_sum;
  logic [UW-1:0]    res_size_u;

  assign rd_parent = rdata_r[IDX_W-1:0];
  assign rd_size   = rdata_r[WORD_W-1:IDX_W];

  assign nc_u  = UW'(node_count_r);
  assign n_use = (nc_u > MAXN_U) ? MAXN_U : nc_u;
  assign a_u   = UW'(in_node_a);
  assign b_u   = UW'(in_node_b);
  assign a_idx = a_u[IDX_W-1:0];
  assign b_idx = b_u[IDX_W-1:0];

  assign b_big      = size_b_r > size_a_r;
  assign big_idx    = b_big ? root_r : ra_r;
  assign small_idx  = b_big ? ra_r : root_r;
  assign small_size = b_big ? size_a_r : size_b_r;
  assign size_sum   = (SZ_W + 1)'(size_a_r) + (SZ_W + 1)'(size_b_r);
  assign size_sat   = (size_sum > MAXN_S) ? MAXN_S[SZ_W-1:0] : size_sum[SZ_W-1:0];
  assign total_sum  = (TOTAL_W + 1)'(total_r) + (TOTAL_W + 1)'(w_r);
  assign res_size_u = UW'(res_size_r);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[mem_raddr];
  end

  always_comb begin
    state_nxt        = state_r;
    total_nxt        = total_r;
    cnt_nxt          = cnt_r;
    sweep_end_nxt    = sweep_end_r;
    cur_nxt          = cur_r;
    start_nxt        = start_r;
    node_b_nxt       = node_b_r;
    root_nxt         = root_r;
    ra_nxt           = ra_r;
    size_a_nxt       = size_a_r;
    size_b_nxt       = size_b_r;
    side_nxt         = side_r;
    w_nxt            = w_r;
    res_acc_nxt      = res_acc_r;
    res_bad_nxt      = res_bad_r;
    res_size_nxt     = res_size_r;
    out_valid_nxt    = out_valid_r && !out_ready;
    out_accepted_nxt = out_accepted_r;
    out_bad_node_nxt = out_bad_node_r;
    out_total_nxt    = out_total_r;
    out_size_nxt     = out_size_r;
    mem_we           = 1'b0;
    mem_waddr        = cur_r;
    mem_wdata        = '0;
    mem_raddr        = cur_r;
    in_ready         = 1'b0;

    unique case (state_r)
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_r[IDX_W-1:0];
        mem_wdata = {SZ_W'(1), cnt_r[IDX_W-1:0]};
        if (cnt_r == LAST_C) begin
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          w_nxt        = in_edge_weight;
          res_acc_nxt  = 1'b0;
          res_bad_nxt  = 1'b0;
          res_size_nxt = '0;
          if (in_op == OP_CLEAR) begin
            total_nxt     = '0;
            cnt_nxt       = '0;
            sweep_end_nxt = n_use[CNT_W-1:0];
            state_nxt     = ST_SWEEP;
          end else if (a_u >= n_use || b_u >= n_use) begin
            res_bad_nxt = 1'b1;
            state_nxt   = ST_DONE;
          end else begin
            cur_nxt    = a_idx;
            start_nxt  = a_idx;
            node_b_nxt = b_idx;
            side_nxt   = 1'b0;
            cnt_nxt    = '0;
            mem_raddr  = a_idx;
            state_nxt  = ST_WALK;
          end
        end
      end
      ST_SWEEP: begin
        if (cnt_r == sweep_end_r) begin
          state_nxt = ST_DONE;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = cnt_r[IDX_W-1:0];
          mem_wdata = {SZ_W'(1), cnt_r[IDX_W-1:0]};
          cnt_nxt   = cnt_r + 1'b1;
        end
      end
      ST_WALK: begin
        if (rd_parent == cur_r || cnt_r == MAXN_C) begin
          root_nxt = cur_r;
          if (side_r) begin
            size_b_nxt = rd_size;
          end else begin
            size_a_nxt = rd_size;
          end
          cur_nxt   = start_r;
          cnt_nxt   = '0;
          state_nxt = ST_COMP_RD;
        end else begin
          cur_nxt   = rd_parent;
          cnt_nxt   = cnt_r + 1'b1;
          mem_raddr = rd_parent;
        end
      end
      ST_COMP_RD: begin
        if (cur_r == root_r || cnt_r == MAXN_C) begin
          if (!side_r) begin
            ra_nxt     = root_r;
            side_nxt   = 1'b1;
            cur_nxt    = node_b_r;
            start_nxt  = node_b_r;
            cnt_nxt    = '0;
            mem_raddr  = node_b_r;
            state_nxt  = ST_WALK;
          end else if (root_r == ra_r) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_MERGE_SMALL;
          end
        end else begin
          state_nxt = ST_COMP_WR;
        end
      end
      ST_COMP_WR: begin
        mem_we    = 1'b1;
        mem_waddr = cur_r;
        mem_wdata = {rd_size, root_r};
        cur_nxt   = rd_parent;
        cnt_nxt   = cnt_r + 1'b1;
        state_nxt = ST_COMP_RD;
      end
      ST_MERGE_SMALL: begin
        mem_we       = 1'b1;
        mem_waddr    = small_idx;
        mem_wdata    = {small_size, big_idx};
        res_size_nxt = size_sat;
        state_nxt    = ST_MERGE_BIG;
      end
      ST_MERGE_BIG: begin
        mem_we      = 1'b1;
        mem_waddr   = big_idx;
        mem_wdata   = {res_size_r, big_idx};
        total_nxt   = total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
        res_acc_nxt = 1'b1;
        state_nxt   = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt    = 1'b1;
          out_accepted_nxt = res_acc_r;
          out_bad_node_nxt = res_bad_r;
          out_total_nxt    = total_r;
          out_size_nxt     = res_size_u[SIZE_OUT_W-1:0];
          state_nxt        = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_INIT;
      node_count_r <= NODE_COUNT_RST;
      total_r      <= '0;
      cnt_r        <= '0;
      sweep_end_r  <= '0;
      side_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      node_count_r <= cfg_wr_en ? cfg_wr_data : node_count_r;
      total_r      <= total_nxt;
      cnt_r        <= cnt_nxt;
      sweep_end_r  <= sweep_end_nxt;
      side_r       <= side_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r          <= cur_nxt;
    start_r        <= start_nxt;
    node_b_r       <= node_b_nxt;
    root_r         <= root_nxt;
    ra_r           <= ra_nxt;
    size_a_r       <= size_a_nxt;
    size_b_r       <= size_b_nxt;
    w_r            <= w_nxt;
    res_acc_r      <= res_acc_nxt;
    res_bad_r      <= res_bad_nxt;
    res_size_r     <= res_size_nxt;
    out_accepted_r <= out_accepted_nxt;
    out_bad_node_r <= out_bad_node_nxt;
    out_total_r    <= out_total_nxt;
    out_size_r     <= out_size_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_accepted      = out_accepted_r;
  assign out_bad_node      = out_bad_node_r;
  assign out_running_total = out_total_r;
  assign out_merged_size   = out_size_r;

  a_bad_not_merged: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_node |-> !out_accepted && out_merged_size == '0)
    else $error("bad-node item reported as merged");

  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !mem_we)
    else $error("node memory written while idle");

  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK || state_r == ST_COMP_RD || state_r == ST_COMP_WR)
      |-> cnt_r <= MAXN_C)
    else $error("walk step count beyond node limit");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r) == ST_DONE)
    else $error("result raised outside completion");

endmodule

### test/kruskal_edge_union_find_test.sv
// Testbench for the Kruskal union-find engine: random and directed edge items checked by a scoreboard
`timescale 1ns / 1ps

module kruskal_edge_union_find_test;
  import keuf_pkg::*;

  localparam int ITEM_TARGET = 1450;
  localparam logic [DEF_WEIGHT_BITS-1:0] WEIGHT_MAX = '1;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  typedef struct packed {
    logic                  accepted;
    logic                  bad_node;
    logic [TOTAL_W-1:0]    total;
    logic [SIZE_OUT_W-1:0] merged;
  } edge_verdict_t;

  class union_find_board;
    logic [NODE_W-1:0]     up_link[DEF_MAX_NODES];
    logic [SIZE_OUT_W-1:0] group_size[DEF_MAX_NODES];
    logic [TOTAL_W-1:0]    sum_so_far;
    logic [COUNT_W-1:0]    live_count;
    edge_verdict_t         pending[$];
    int                    errors;

    function new();
      for (int i = 0; i < DEF_MAX_NODES; i++) begin
        up_link[i] = NODE_W'(i);
        group_size[i] = SIZE_OUT_W'(1);
      end
      sum_so_far = '0;
      live_count = NODE_COUNT_RST;
      errors = 0;
    endfunction

    function int nodes_live();
      return (live_count > DEF_MAX_NODES) ? DEF_MAX_NODES : int'(live_count);
    endfunction

    // walk to the root, then point every node on the path straight at it
    function logic [NODE_W-1:0] find_root(logic [NODE_W-1:0] node);
      logic [NODE_W-1:0] root;
      logic [NODE_W-1:0] nxt;
      int steps;
      root = node;
      steps = 0;
      while (up_link[root] != root && steps < DEF_MAX_NODES) begin
        root = up_link[root];
        steps++;
      end
      steps = 0;
      while (node != root && steps < DEF_MAX_NODES) begin
        nxt = up_link[node];
        up_link[node] = root;
        node = nxt;
        steps++;
      end
      return root;
    endfunction

    function void note_item(logic op, logic [NODE_W-1:0] a, logic [NODE_W-1:0] b,
                            logic [DEF_WEIGHT_BITS-1:0] w);
      edge_verdict_t v;
      logic [NODE_W-1:0] ra, rb, big, minor;
      logic [TOTAL_W:0] sum;
      int n, sz;
      n = nodes_live();
      v = '0;
      if (op == OP_CLEAR) begin
        for (int i = 0; i < n; i++) begin
          up_link[i] = NODE_W'(i);
          group_size[i] = SIZE_OUT_W'(1);
        end
        sum_so_far = '0;
      end else if (int'(a) >= n || int'(b) >= n) begin
        v.bad_node = 1'b1;
        v.total = sum_so_far;
      end else begin
        ra = find_root(a);
        rb = find_root(b);
        if (ra == rb) begin
          v.total = sum_so_far;
        end else begin
          if (group_size[rb] > group_size[ra]) begin
            big = rb;
            minor = ra;
          end else begin
            big = ra;
            minor = rb;
          end
          up_link[minor] = big;
          sz = int'(group_size[big]) + int'(group_size[minor]);
          if (sz > DEF_MAX_NODES) sz = DEF_MAX_NODES;
          group_size[big] = SIZE_OUT_W'(sz);
          sum = {1'b0, sum_so_far} + (TOTAL_W + 1)'(w);
          sum_so_far = (sum > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : sum[TOTAL_W-1:0];
          v.accepted = 1'b1;
          v.total = sum_so_far;
          v.merged = SIZE_OUT_W'(sz);
        end
      end
      pending.push_back(v);
    endfunction

    function void check_result(edge_verdict_t got);
      edge_verdict_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: unexpected result acc=%0b bad=%0b total=%0d size=%0d", $realtime,
                   got.accepted, got.bad_node, got.total, got.merged);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display("%0t: mismatch exp acc/bad/total/size %0b/%0b/%0d/%0d got %0b/%0b/%0d/%0d",
                   $realtime, want.accepted, want.bad_node, want.total, want.merged,
                   got.accepted, got.bad_node, got.total, got.merged);
      end
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic                       in_op = OP_CLEAR;
  logic [NODE_W-1:0]          in_node_a = '0;
  logic [NODE_W-1:0]          in_node_b = '0;
  logic [DEF_WEIGHT_BITS-1:0] in_edge_weight = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic                       out_accepted;
  logic                       out_bad_node;
  logic [TOTAL_W-1:0]         out_running_total;
  logic [SIZE_OUT_W-1:0]      out_merged_size;
  logic                       cfg_wr_en = 1'b0;
  logic [COUNT_W-1:0]         cfg_wr_data = '0;

  union_find_board sb = new();
  int items_sent = 0;
  int src_idle_pct = 20;
  int dst_idle_pct = 81;
  bit hold_request = 1'b0;
  int hold_left = 0;

  kruskal_edge_union_find dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_op             (in_op),
    .in_node_a         (in_node_a),
    .in_node_b         (in_node_b),
    .in_edge_weight    (in_edge_weight),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_accepted      (out_accepted),
    .out_bad_node      (out_bad_node),
    .out_running_total (out_running_total),
    .out_merged_size   (out_merged_size),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // result side: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result({out_accepted, out_bad_node, out_running_total, out_merged_size});
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= dst_idle_pct);
    end
  end

  task automatic send_item(logic op, logic [NODE_W-1:0] a, logic [NODE_W-1:0] b,
                           logic [DEF_WEIGHT_BITS-1:0] w);
    if (items_sent < ITEM_TARGET / 3) begin
      src_idle_pct = 20;
      dst_idle_pct = 81;
    end else if (items_sent < 2 * ITEM_TARGET / 3) begin
      src_idle_pct = 81;
      dst_idle_pct = 20;
    end else begin
      src_idle_pct = 0;
      dst_idle_pct = 0;
    end
    if (items_sent == ITEM_TARGET - 250) hold_request = 1'b1;
    if ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_node_a <= a;
    in_node_b <= b;
    in_edge_weight <= w;
    do @(posedge clk); while (!in_ready);
    sb.note_item(op, a, b, w);
    items_sent++;
  endtask

  task automatic clear_sets();
    send_item(OP_CLEAR, NODE_W'($urandom), NODE_W'($urandom), DEF_WEIGHT_BITS'($urandom));
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_count(logic [COUNT_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.live_count = value;
  endtask

  initial begin
    logic [COUNT_W-1:0] count;
    longint wt;
    int n, phase_len, pick;
    logic [NODE_W-1:0] a, b;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset count of 256, then zero, above range, one, two, raised without clear
    send_item(OP_CLEAR, '1, '1, '1);
    send_item(OP_EDGE, 8'd0, 8'd255, WEIGHT_MAX);
    send_item(OP_EDGE, 8'd255, 8'd0, WEIGHT_MAX);
    send_item(OP_EDGE, 8'd9, 8'd9, '0);
    send_item(OP_EDGE, 8'd4, 8'd5, 31'd1);
    send_item(OP_EDGE, 8'd6, 8'd4, 31'd2);
    send_item(OP_EDGE, 8'd0, 8'd6, 31'd3);
    send_item(OP_EDGE, 8'd5, 8'd255, 31'd4);
    send_item(OP_EDGE, 8'd128, 8'd127, 31'd5);
    clear_sets();
    send_item(OP_EDGE, 8'd1, 8'd2, '0);
    wait_drain();
    write_count('0);
    send_item(OP_EDGE, 8'd0, 8'd0, 31'd7);
    clear_sets();
    send_item(OP_EDGE, 8'd0, 8'd1, 31'd8);
    wait_drain();
    write_count('1);
    send_item(OP_EDGE, 8'd255, 8'd254, 31'd9);
    send_item(OP_EDGE, 8'd254, 8'd255, 31'd10);
    wait_drain();
    write_count(9'd1);
    clear_sets();
    send_item(OP_EDGE, 8'd0, 8'd0, 31'd11);
    send_item(OP_EDGE, 8'd0, 8'd1, 31'd12);
    send_item(OP_EDGE, 8'd1, 8'd0, 31'd13);
    wait_drain();
    write_count(9'd2);
    clear_sets();
    send_item(OP_EDGE, 8'd1, 8'd0, 31'd14);
    wait_drain();
    write_count(NODE_COUNT_RST);
    send_item(OP_EDGE, 8'd0, 8'd200, 31'd15);
    send_item(OP_EDGE, 8'd255, 8'd1, 31'd16);

    // random phases: one node count each, mostly a clear then ascending edges
    while (items_sent < ITEM_TARGET) begin
      pick = $urandom_range(99);
      if (pick < 55) count = COUNT_W'($urandom_range(3, 32));
      else if (pick < 72) count = NODE_COUNT_RST;
      else if (pick < 84) count = COUNT_W'($urandom_range(33, 255));
      else if (pick < 90) count = COUNT_W'($urandom_range(257, 511));
      else if (pick < 94) count = '0;
      else count = COUNT_W'($urandom_range(1, 2));
      wait_drain();
      write_count(count);
      n = sb.nodes_live();
      phase_len = $urandom_range(20, 60);
      if ($urandom_range(9) != 0) clear_sets();
      wt = longint'($urandom_range(0, 32'h7FFF_FFFF) >> $urandom_range(0, 30));
      repeat (phase_len) begin
        pick = $urandom_range(99);
        wt = wt + $urandom_range(0, 1 << $urandom_range(0, 24));
        if (wt > longint'(WEIGHT_MAX)) wt = longint'(WEIGHT_MAX);
        if (pick < 80 && n > 0) begin
          a = NODE_W'($urandom_range(0, n - 1));
          b = NODE_W'($urandom_range(0, n - 1));
          send_item(OP_EDGE, a, b, DEF_WEIGHT_BITS'(wt));
        end else if (pick < 88 && n < DEF_MAX_NODES) begin
          a = NODE_W'($urandom_range(n, DEF_MAX_NODES - 1));
          b = NODE_W'($urandom);
          if ($urandom_range(1)) send_item(OP_EDGE, a, b, DEF_WEIGHT_BITS'(wt));
          else send_item(OP_EDGE, b, a, DEF_WEIGHT_BITS'(wt));
        end else if (pick < 95) begin
          send_item(OP_EDGE, NODE_W'($urandom), NODE_W'($urandom),
                    DEF_WEIGHT_BITS'($urandom));
        end else begin
          clear_sets();
          wt = longint'($urandom_range(0, 32'h7FFF_FFFF) >> $urandom_range(0, 30));
        end
      end
    end

    wait_drain();
    repeat (300) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
